// ----- hdl/lz_byte_window_depacker_core_assert.svh -----
// Assertion macros shared by the depacker RTL.
`ifndef LZ_BYTE_WINDOW_DEPACKER_CORE_ASSERT_SVH
`define LZ_BYTE_WINDOW_DEPACKER_CORE_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define LZBWD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define LZBWD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- hdl/lzbwd_pkg.sv -----
// Types and constants of the byte-window LZ depacker.
`timescale 1ns / 1ps
package lzbwd_pkg;

  localparam int Lanes    = 4;                  // decoded bytes per result beat
  localparam int LaneW    = $clog2(Lanes + 1);  // holds 0..Lanes
  localparam int WinDepth = 256;                // history window bytes
  localparam int WinIdxW  = $clog2(WinDepth);

  localparam logic [7:0] MatchShortMin = 8'h80;  // token bytes at or above: short match
  localparam logic [7:0] ShortLen      = 8'd2;
  localparam logic [7:0] FlagMarker    = 8'h80;  // sentinel bit of a loaded flag byte

  typedef enum logic [1:0] {
    PH_START,
    PH_LITERAL,
    PH_MATCH,
    PH_INDEX
  } phase_e;

  typedef enum logic [1:0] {
    ST_TAKE,
    ST_COPY,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic [31:0] out_bytes;
    logic [2:0]  byte_count;
    logic        stream_end;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic               push;
    logic [7:0]         push_data;
    logic               tap_load;
    logic [WinIdxW-1:0] tap_idx;
  } win_ctrl_t;

endpackage

// ----- hdl/lzbwd_if.sv -----
// Valid/ready channel interfaces of the depacker.
`timescale 1ns / 1ps
interface lzbwd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;

  modport source (output valid, output packed_byte, input ready);
  modport sink (input valid, input packed_byte, output ready);
endinterface

interface lzbwd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_bytes;
  logic [2:0]  byte_count;
  logic        stream_end;
  logic        last_of_run;

  modport source (output valid, output out_bytes, output byte_count, output stream_end,
                  output last_of_run, input ready);
  modport sink (input valid, input out_bytes, input byte_count, input stream_end,
                input last_of_run, output ready);
endinterface

// ----- hdl/lzbwd_cell.sv -----
// One byte cell of the history chain with its copy-tap flag.
`timescale 1ns / 1ps
module lzbwd_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic [7:0] data_i,
  input  logic       tap_load_i,
  input  logic       tap_hit_i,
  output logic [7:0] data_o,
  output logic [7:0] tap_rd_o
);
  logic [7:0] data_q;
  logic       tap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
      tap_q  <= 1'b0;
    end else begin
      if (shift_i) begin
        data_q <= data_i;
      end
      if (tap_load_i) begin
        tap_q <= tap_hit_i;
      end
    end
  end

  assign data_o   = data_q;
  assign tap_rd_o = {8{tap_q}} & data_q;
endmodule

// ----- hdl/lzbwd_window.sv -----
// History window: chain of byte cells, newest byte in cell 0, one tapped cell read.
`timescale 1ns / 1ps
module lzbwd_window (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lzbwd_pkg::win_ctrl_t ctrl_i,
  output logic [7:0]           rd_data_o
);
  import lzbwd_pkg::*;

  logic [7:0] cell_data [WinDepth];
  logic [7:0] cell_tap  [WinDepth];

  for (genvar k = 0; k < WinDepth; k++) begin : g_cell
    logic [7:0] chain_in;
    logic       hit;

    if (k == 0) begin : g_head
      assign chain_in = ctrl_i.push_data;
    end else begin : g_body
      assign chain_in = cell_data[k-1];
    end

    // cell k holds the byte at distance k+1
    assign hit = (ctrl_i.tap_idx == WinIdxW'(k));

    lzbwd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (ctrl_i.push),
      .data_i     (chain_in),
      .tap_load_i (ctrl_i.tap_load),
      .tap_hit_i  (hit),
      .data_o     (cell_data[k]),
      .tap_rd_o   (cell_tap[k])
    );
  end

  // tap flags are one-hot, so the OR of masked cells is the tapped byte
  always_comb begin
    rd_data_o = '0;
    for (int k = 0; k < WinDepth; k++) begin
      rd_data_o = rd_data_o | cell_tap[k];
    end
  end
endmodule

// ----- hdl/lzbwd_outbuf.sv -----
// Two-entry result buffer in front of the output channel.
`timescale 1ns / 1ps
module lzbwd_outbuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lzbwd_pkg::result_t data_i,
  output logic               room_o,
  lzbwd_out_if.source        out_o
);
  import lzbwd_pkg::*;

  result_t    ent0_q, ent1_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop    = out_o.valid && out_o.ready;
  assign room_o = (cnt_q != 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && cnt_q == 2'd2) begin
      ent0_q <= ent1_q;
    end else if (push_i && ((pop && cnt_q == 2'd1) || (!pop && cnt_q == 2'd0))) begin
      ent0_q <= data_i;
    end
    if (push_i && !pop && cnt_q == 2'd1) begin
      ent1_q <= data_i;
    end
  end

  assign out_o.valid       = (cnt_q != 2'd0);
  assign out_o.out_bytes   = ent0_q.out_bytes;
  assign out_o.byte_count  = ent0_q.byte_count;
  assign out_o.stream_end  = ent0_q.stream_end;
  assign out_o.last_of_run = ent0_q.last_of_run;
endmodule

// ----- hdl/lz_byte_window_depacker_core.sv -----
// Byte-window LZ depacker top: token parser, match copy sequencer, lane packer.
//
//  channel  dir  beat                                              handshake
//  in_i     in   packed_byte[7:0]                                  valid/ready
//  out_o    out  out_bytes[31:0] byte_count[2:0] stream_end last   valid/ready
//
// A match of L bytes is copied after its last input byte: one byte per cycle while a
// result slot is free, read from the tapped window cell, giving ceil(L/4) result beats.
// Reset clears the 256 window cells and all control at once; no clearing pass.
// in_i.ready is low during a copy and, before the end token, while both result slots
// are occupied; a copy pauses while both slots are occupied. After the end token every
// byte is taken and dropped until reset.
`timescale 1ns / 1ps
`include "lz_byte_window_depacker_core_assert.svh"
module lz_byte_window_depacker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  lzbwd_in_if.sink    in_i,
  lzbwd_out_if.source out_o
);
  import lzbwd_pkg::*;

  ctrl_state_e      state_q, state_d;
  phase_e           phase_q, phase_d;
  logic [7:0]       flag_q, flag_d;
  logic [7:0]       pend_q, pend_d;
  logic [7:0]       rem_q, rem_d;
  logic [LaneW-1:0] lane_q, lane_d;
  logic [31:0]      acc_q, acc_d;

  logic       room;
  logic       take, step;
  logic       in_ready;
  logic [7:0] b;
  logic [7:0] flag_sh;
  logic       flag_load, body_active, body_bit;
  logic       is_lit, is_short, is_len, is_end, is_long;
  logic [7:0] win_rd;
  logic [31:0] acc_nx;
  logic [LaneW-1:0] lane_inc;
  logic       emit;

  win_ctrl_t win_ctrl;
  result_t   res;
  logic      res_push;

  // token decode of the incoming byte
  always_comb begin
    b           = in_i.packed_byte;
    flag_sh     = flag_q >> 1;
    flag_load   = (phase_q == PH_START) && (flag_sh == '0);
    body_active = ((phase_q == PH_START) && !flag_load) ||
                  (phase_q == PH_LITERAL) || (phase_q == PH_MATCH);
    case (phase_q)
      PH_MATCH:   body_bit = 1'b1;
      PH_LITERAL: body_bit = 1'b0;
      default:    body_bit = flag_q[0];
    endcase
    is_lit   = body_active && !body_bit;
    is_short = body_active && body_bit && (b >= MatchShortMin);
    is_len   = body_active && body_bit && (b < MatchShortMin);
    is_end   = (phase_q == PH_INDEX) && (pend_q == '0);
    is_long  = (phase_q == PH_INDEX) && (pend_q != '0);
    take     = in_i.valid && room && (state_q == ST_TAKE);
    step     = (state_q == ST_COPY) && room;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_TAKE: begin
        if (take && (is_short || is_long)) begin
          state_d = ST_COPY;
        end else if (take && is_end) begin
          state_d = ST_DONE;
        end
      end
      ST_COPY: begin
        if (step && rem_q == 8'd1) begin
          state_d = ST_TAKE;
        end
      end
      ST_DONE: state_d = ST_DONE;
      default: state_d = ST_TAKE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    phase_d  = phase_q;
    flag_d   = flag_q;
    pend_d   = pend_q;
    rem_d    = rem_q;
    lane_d   = lane_q;
    acc_d    = acc_q;
    win_ctrl = '0;
    res      = '0;
    res_push = 1'b0;
    in_ready = 1'b0;
    acc_nx   = acc_q | (32'(win_rd) << {lane_q, 3'b000});
    lane_inc = lane_q + LaneW'(1);
    emit     = (lane_q == LaneW'(Lanes - 1)) || (rem_q == 8'd1);

    case (state_q)
      ST_TAKE: begin
        in_ready = room;
        if (take) begin
          if (phase_q == PH_START) begin
            flag_d = flag_sh;
          end
          if (flag_load) begin
            flag_d  = (b >> 1) | FlagMarker;
            phase_d = b[0] ? PH_MATCH : PH_LITERAL;
          end
          if (is_lit) begin
            win_ctrl.push      = 1'b1;
            win_ctrl.push_data = b;
            res                = '{out_bytes: 32'(b), byte_count: 3'd1,
                                   stream_end: 1'b0, last_of_run: 1'b1};
            res_push           = 1'b1;
            phase_d            = PH_START;
          end
          if (is_len) begin
            pend_d  = b;
            phase_d = PH_INDEX;
          end
          if (is_end) begin
            res      = '{out_bytes: '0, byte_count: 3'd0,
                         stream_end: 1'b1, last_of_run: 1'b1};
            res_push = 1'b1;
            phase_d  = PH_START;
          end
          if (is_short || is_long) begin
            // distance 256 - b sits in cell 255 - b
            win_ctrl.tap_load = 1'b1;
            win_ctrl.tap_idx  = ~b;
            rem_d             = is_short ? ShortLen : pend_q;
            lane_d            = '0;
            acc_d             = '0;
            phase_d           = PH_START;
          end
        end
      end
      ST_COPY: begin
        if (step) begin
          win_ctrl.push      = 1'b1;
          win_ctrl.push_data = win_rd;
          rem_d              = rem_q - 8'd1;
          if (emit) begin
            res      = '{out_bytes: acc_nx, byte_count: 3'(lane_inc),
                         stream_end: 1'b0, last_of_run: (rem_q == 8'd1)};
            res_push = 1'b1;
            lane_d   = '0;
            acc_d    = '0;
          end else begin
            lane_d = lane_inc;
            acc_d  = acc_nx;
          end
        end
      end
      ST_DONE: in_ready = 1'b1;
      default: in_ready = 1'b0;
    endcase
  end

  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_TAKE;
      phase_q <= PH_START;
      flag_q  <= '0;
      pend_q  <= '0;
      rem_q   <= '0;
      lane_q  <= '0;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      flag_q  <= flag_d;
      pend_q  <= pend_d;
      rem_q   <= rem_d;
      lane_q  <= lane_d;
      acc_q   <= acc_d;
    end
  end

  lzbwd_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (win_ctrl),
    .rd_data_o (win_rd)
  );

  lzbwd_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .room_o (room),
    .out_o  (out_o)
  );

  `LZBWD_ASSERT(a_push_room, res_push |-> room, "result pushed into a full buffer")
  `LZBWD_ASSERT(a_copy_len, (state_q == ST_COPY) |-> (rem_q != 8'd0), "copy with no bytes left")
  `LZBWD_ASSERT_NEXT(a_copy_ends, step && (rem_q == 8'd1), state_q == ST_TAKE, "copy overran")
  `LZBWD_ASSERT_NEXT(a_done_stays, state_q == ST_DONE, state_q == ST_DONE, "left end state")
  `LZBWD_ASSERT(a_done_quiet, (state_q == ST_DONE) |-> !(res_push || win_ctrl.push), "end busy")
endmodule

// ----- test/tb.sv -----
// Self-checking testbench of the byte-window LZ depacker core.
`timescale 1ns / 1ps

module tb;
  import lzbwd_pkg::*;

  // What the next packed byte means to the parser.
  typedef enum logic [1:0] {
    SLOT_FLAG,
    SLOT_LITERAL,
    SLOT_MATCH,
    SLOT_INDEX
  } stream_slot_e;

  class depack_scoreboard;
    logic [7:0] window [WinDepth];
    logic [7:0] wr_pos;
    logic [7:0] flags;
    phase_e     phase;
    logic [7:0] pend_len;
    bit         stream_done;
    result_t    expected_beats [$];
    int         errors;

    function new();
      foreach (window[i]) window[i] = 8'h00;
      wr_pos      = 8'h00;
      flags       = 8'h00;
      phase       = PH_START;
      pend_len    = 8'h00;
      stream_done = 1'b0;
      errors      = 0;
    endfunction

    function stream_slot_e next_slot();
      case (phase)
        PH_START:   if ((flags >> 1) == 8'h00) return SLOT_FLAG;
                    else return flags[0] ? SLOT_MATCH : SLOT_LITERAL;
        PH_LITERAL: return SLOT_LITERAL;
        PH_MATCH:   return SLOT_MATCH;
        default:    return SLOT_INDEX;
      endcase
    endfunction

    function void push_window(logic [7:0] v);
      window[wr_pos] = v;
      wr_pos = wr_pos + 8'd1;
    endfunction

    // Byte-by-byte copy, so a short distance repeats bytes produced by this match.
    function void copy_run(logic [7:0] len, logic [7:0] idx);
      result_t     r;
      int          n;
      int          lane;
      logic [31:0] acc;
      logic [7:0]  rd;
      logic [7:0]  v;
      lane = 0;
      acc  = 32'h0;
      for (n = 0; n < int'(len); n++) begin
        rd = wr_pos + idx;
        v  = window[rd];
        push_window(v);
        acc = acc | (32'(v) << (8 * lane));
        lane++;
        if (lane == Lanes || n + 1 == int'(len)) begin
          r.out_bytes   = acc;
          r.byte_count  = 3'(lane);
          r.stream_end  = 1'b0;
          r.last_of_run = 1'b0;
          expected_beats.push_back(r);
          lane = 0;
          acc  = 32'h0;
        end
      end
    endfunction

    function void take_token(logic is_match, logic [7:0] b);
      result_t r;
      if (!is_match) begin
        push_window(b);
        r.out_bytes   = 32'(b);
        r.byte_count  = 3'd1;
        r.stream_end  = 1'b0;
        r.last_of_run = 1'b0;
        expected_beats.push_back(r);
        phase = PH_START;
      end else if (b >= MatchShortMin) begin
        phase = PH_START;
        copy_run(ShortLen, b);
      end else begin
        pend_len = b;
        phase    = PH_INDEX;
      end
    endfunction

    function void note_byte(logic [7:0] b);
      int      before_n;
      logic    tok;
      result_t r;
      if (stream_done) return;
      before_n = expected_beats.size();
      case (phase)
        PH_START: begin
          tok   = flags[0];
          flags = flags >> 1;
          if (flags == 8'h00) begin
            flags = (b >> 1) | FlagMarker;
            phase = b[0] ? PH_MATCH : PH_LITERAL;
          end else begin
            take_token(tok, b);
          end
        end
        PH_LITERAL: take_token(1'b0, b);
        PH_MATCH:   take_token(1'b1, b);
        default: begin
          phase = PH_START;
          if (pend_len == 8'h00) begin
            stream_done   = 1'b1;
            r.out_bytes   = 32'h0;
            r.byte_count  = 3'd0;
            r.stream_end  = 1'b1;
            r.last_of_run = 1'b0;
            expected_beats.push_back(r);
          end else begin
            copy_run(pend_len, b);
          end
        end
      endcase
      if (expected_beats.size() > before_n) begin
        r = expected_beats.pop_back();
        r.last_of_run = 1'b1;
        expected_beats.push_back(r);
      end
    endfunction

    function void check_beat(result_t got);
      result_t want;
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: out_bytes %h byte_count %0d", got.out_bytes,
               got.byte_count);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      if (got.out_bytes !== want.out_bytes) begin
        $error("out_bytes: expected %h, actual %h", want.out_bytes, got.out_bytes);
        errors++;
      end
      if (got.byte_count !== want.byte_count) begin
        $error("byte_count: expected %0d, actual %0d", want.byte_count, got.byte_count);
        errors++;
      end
      if (got.stream_end !== want.stream_end) begin
        $error("stream_end: expected %b, actual %b", want.stream_end, got.stream_end);
        errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %b, actual %b", want.last_of_run, got.last_of_run);
        errors++;
      end
    endfunction
  endclass

  localparam int IdlePct       = 26;
  localparam int RandomBytes   = 140;
  localparam int WatchdogLimit = 2000;
  localparam int TailCycles    = 300;
  localparam int DirectedN     = 23;

  // Flag 0xAC: literals 00/FF/A5/5A, short matches 80/FF, len 1 at index 0, len 127 at
  // index FF; flag 0x00: eight literals; flag 0xFF: len 3 at index 01.
  localparam logic [7:0] Directed [DirectedN] = '{
    8'hAC, 8'h00, 8'hFF, 8'h80, 8'hFF, 8'hA5, 8'h01, 8'h00, 8'h5A, 8'h7F, 8'hFF,
    8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'hFF, 8'h03, 8'h01
  };

  logic clk;
  logic rst_n;
  bit   calm;
  int   quiet_cycles;

  depack_scoreboard sb;
  result_t          seen;

  lzbwd_in_if  in_if ();
  lzbwd_out_if out_if ();

  lz_byte_window_depacker_core u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] rand_byte(int lo, int hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.packed_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Walks the parser to a match token and gives it length zero.
  task automatic send_end_token();
    while (!sb.stream_done) begin
      case (sb.next_slot())
        SLOT_FLAG:  send_byte(rand_byte(0, 255) | 8'h01);
        SLOT_MATCH: send_byte(8'h00);
        default:    send_byte(rand_byte(0, 255));
      endcase
    end
  endtask

  always @(negedge clk) begin
    out_if.ready <= calm || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_byte(in_if.packed_byte);
      if (out_if.valid && out_if.ready) begin
        seen.out_bytes   = out_if.out_bytes;
        seen.byte_count  = out_if.byte_count;
        seen.stream_end  = out_if.stream_end;
        seen.last_of_run = out_if.last_of_run;
        sb.check_beat(seen);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int           n;
    logic [7:0]   b;
    stream_slot_e slot;
    sb                = new();
    calm              = 1'b0;
    quiet_cycles      = 0;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.packed_byte = 8'h00;
    out_if.ready      = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (n = 0; n < DirectedN; n++) send_byte(Directed[n]);

    // Mostly well-formed tokens; some raw bytes, which may bring long lengths.
    for (n = 0; n < RandomBytes; n++) begin
      calm = (n >= 70 && n < 110);
      slot = sb.next_slot();
      b    = rand_byte(0, 255);
      if ($urandom_range(99) < 15) begin
        if (slot == SLOT_MATCH && b == 8'h00) b = 8'h01;
      end else if (slot == SLOT_MATCH) begin
        if ($urandom_range(1) == 1) b = rand_byte(128, 255);
        else if ($urandom_range(9) != 0) b = rand_byte(1, 8);
        else b = rand_byte(9, 127);
      end
      send_byte(b);
    end
    calm = 1'b0;

    send_end_token();
    // bytes after the end token are dropped
    repeat (3) send_byte(rand_byte(0, 255));
    in_if.valid <= 1'b0;

    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (sb.expected_beats.size() != 0) begin
      $error("result beats still expected: %0d", sb.expected_beats.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
